@@ design/pmsfp_pkg.sv @@
package pmsfp_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 32;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] SYNC_FIRST  = 8'h42;
  localparam logic [7:0] SYNC_SECOND = 8'h4D;

  localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SECOND  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CK_HI   = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] ADDR_WORDS  = POS_W'(4);
  localparam logic [POS_W-1:0] ADDR_VERSION = POS_W'(FRAME_BYTES - 4);
  localparam logic [POS_W-1:0] ADDR_ERROR  = POS_W'(FRAME_BYTES - 3);

  localparam logic [15:0] LEN_EXPECT = 16'(FRAME_BYTES - 4);

  // Result fields
  localparam logic [3:0] FIELD_FIRST_BYTE = 4'd12;
  localparam logic [3:0] FIELD_LAST       = 4'd13;

  // Status codes
  localparam logic [1:0] STAT_FIELD   = 2'd0;
  localparam logic [1:0] STAT_BAD     = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;

  // Input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Controller to datapath
  typedef struct packed {
    logic       take;
    logic       load_stat;
    logic [1:0] stat;
    logic       load_field;
    logic       cap_hi;
    logic       rd_lo;
    logic [3:0] idx;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic good_end;
    logic bad_end;
    logic tick_fire;
  } dp_stat_t;

endpackage

@@ design/pmsfp_if.sv @@
interface pmsfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface pmsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  field_index;
  logic [15:0] value;
  logic        last;

  modport source (output valid, output status, output field_index, output value,
                  output last, input ready);
  modport sink   (input valid, input status, input field_index, input value,
                  input last, output ready);
endinterface

interface pmsfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/pmsfp_datapath.sv @@
module pmsfp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                kind,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  pmsfp_pkg::ctl_cmd_t cmd,
  output pmsfp_pkg::dp_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [3:0]          out_field_index,
  output logic [15:0]         out_value,
  output logic                out_last
);

  logic [pmsfp_pkg::POS_W-1:0] byte_position;
  logic [15:0]                 running_sum;
  logic [15:0]                 tick_count;
  logic [15:0]                 timeout_ticks;
  logic [7:0]                  len_hi;
  logic [7:0]                  len_lo;
  logic [7:0]                  ck_hi;
  logic [7:0]                  hi_byte;
  logic [7:0]                  rd_data;
  logic [7:0]                  frame_store [pmsfp_pkg::FRAME_BYTES];

  logic                        is_byte;
  logic                        is_tick;
  logic                        hunt_drop;
  logic                        second_bad;
  logic                        store_byte;
  logic                        frame_end;
  logic                        frame_good;
  logic [15:0]                 tick_inc;
  logic                        tick_on;
  logic [pmsfp_pkg::POS_W-1:0] rd_addr;
  logic [pmsfp_pkg::POS_W-1:0] word_addr;

  // Classify the incoming word
  always_comb begin
    is_byte    = (kind == pmsfp_pkg::KIND_BYTE);
    is_tick    = (kind == pmsfp_pkg::KIND_TICK);
    hunt_drop  = (byte_position == pmsfp_pkg::POS_FIRST) && (rx_byte != pmsfp_pkg::SYNC_FIRST);
    second_bad = (byte_position == pmsfp_pkg::POS_SECOND) &&
                 (rx_byte != pmsfp_pkg::SYNC_SECOND);
    store_byte = is_byte && !hunt_drop && !second_bad;
    frame_end  = store_byte && (byte_position == pmsfp_pkg::POS_LAST);
    frame_good = ({len_hi, len_lo} == pmsfp_pkg::LEN_EXPECT) &&
                 ({ck_hi, rx_byte} == running_sum);
  end

  // Saturating tick count and timeout compare
  always_comb begin
    tick_inc = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
    tick_on  = is_tick && (timeout_ticks != 16'd0);
  end

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.good_end  = frame_end && frame_good;
  assign stat.bad_end   = frame_end && !frame_good;
  assign stat.tick_fire = tick_on && (tick_inc >= timeout_ticks);

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= pmsfp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Frame position and running checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= pmsfp_pkg::POS_FIRST;
      running_sum   <= 16'd0;
    end else if (cmd.take && is_byte) begin
      if (second_bad) begin
        byte_position <= (rx_byte == pmsfp_pkg::SYNC_FIRST) ? pmsfp_pkg::POS_SECOND
                                                            : pmsfp_pkg::POS_FIRST;
      end else if (store_byte) begin
        byte_position <= byte_position + pmsfp_pkg::POS_W'(1);
        if (byte_position == pmsfp_pkg::POS_FIRST) begin
          running_sum <= {8'd0, rx_byte};
        end else if (byte_position < pmsfp_pkg::POS_CK_HI) begin
          running_sum <= running_sum + {8'd0, rx_byte};
        end
      end
    end
  end

  // Tick counter: restart on a good frame or a timeout
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 16'd0;
    end else if (cmd.take) begin
      if (stat.good_end || stat.tick_fire) begin
        tick_count <= 16'd0;
      end else if (tick_on) begin
        tick_count <= tick_inc;
      end
    end
  end

  // Capture length and checksum high byte as they pass
  always_ff @(posedge clk) begin
    if (cmd.take && store_byte) begin
      if (byte_position == pmsfp_pkg::POS_LEN_HI) begin
        len_hi <= rx_byte;
      end
      if (byte_position == pmsfp_pkg::POS_LEN_LO) begin
        len_lo <= rx_byte;
      end
      if (byte_position == pmsfp_pkg::POS_CK_HI) begin
        ck_hi <= rx_byte;
      end
    end
  end

  // Read address for the field being emitted
  always_comb begin
    word_addr = pmsfp_pkg::ADDR_WORDS + pmsfp_pkg::POS_W'({cmd.idx, 1'b0});
    if (cmd.idx == pmsfp_pkg::FIELD_FIRST_BYTE) begin
      rd_addr = pmsfp_pkg::ADDR_VERSION;
    end else if (cmd.idx == pmsfp_pkg::FIELD_LAST) begin
      rd_addr = pmsfp_pkg::ADDR_ERROR;
    end else begin
      rd_addr = cmd.rd_lo ? word_addr + pmsfp_pkg::POS_W'(1) : word_addr;
    end
  end

  // Frame store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.take && store_byte) begin
      frame_store[byte_position] <= rx_byte;
    end
    rd_data <= frame_store[rd_addr];
  end

  // Hold the high byte of a word
  always_ff @(posedge clk) begin
    if (cmd.cap_hi) begin
      hi_byte <= rd_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_stat || cmd.load_field) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stat) begin
      out_status      <= cmd.stat;
      out_field_index <= 4'd0;
      out_value       <= 16'd0;
      out_last        <= 1'b1;
    end else if (cmd.load_field) begin
      out_status      <= pmsfp_pkg::STAT_FIELD;
      out_field_index <= cmd.idx;
      out_value       <= (cmd.idx < pmsfp_pkg::FIELD_FIRST_BYTE) ? {hi_byte, rd_data}
                                                                 : {8'd0, rd_data};
      out_last        <= (cmd.idx == pmsfp_pkg::FIELD_LAST);
    end
  end

endmodule

@@ design/pmsfp_ctrl.sv @@
module pmsfp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmsfp_pkg::dp_stat_t stat,
  output pmsfp_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RD_HI = 2'd1;
  localparam logic [1:0] S_RD_LO = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [3:0] idx;
  logic [3:0] idx_next;
  logic [3:0] idx_inc;

  assign idx_inc = idx + 4'd1;

  // Sequence the 14-field run and take input words when idle
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    in_ready       = 1'b0;
    cmd.take       = 1'b0;
    cmd.load_stat  = 1'b0;
    cmd.stat       = pmsfp_pkg::STAT_BAD;
    cmd.load_field = 1'b0;
    cmd.cap_hi     = 1'b0;
    cmd.rd_lo      = 1'b0;
    cmd.idx        = idx;
    unique case (state)
      S_IDLE: begin
        in_ready = stat.out_free;
        cmd.take = in_ready && in_valid;
        if (cmd.take) begin
          if (stat.bad_end) begin
            cmd.load_stat = 1'b1;
            cmd.stat      = pmsfp_pkg::STAT_BAD;
          end else if (stat.tick_fire) begin
            cmd.load_stat = 1'b1;
            cmd.stat      = pmsfp_pkg::STAT_TIMEOUT;
          end else if (stat.good_end) begin
            idx_next   = 4'd0;
            state_next = S_RD_HI;
          end
        end
      end
      S_RD_HI: begin
        state_next = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.rd_lo  = 1'b1;
        cmd.cap_hi = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.rd_lo = 1'b1;
        if (stat.out_free) begin
          cmd.load_field = 1'b1;
          if (idx == pmsfp_pkg::FIELD_LAST) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = (idx_inc >= pmsfp_pkg::FIELD_FIRST_BYTE) ? S_RD_LO : S_RD_HI;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 4'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

@@ design/pm_sensor_frame_parser_core.sv @@
// Channel  Role  Payload                              Handshake
// item     sink  kind, rx_byte                        valid/ready
// result   src   status, field_index, value, last     valid/ready
// cfg      sink  data (timeout_ticks)                 valid/ready, ready always high
//
// A bad-frame or timeout status leaves on the next cycle after its byte or tick is taken.
// On a good frame end, 12 words each pass S_RD_HI, S_RD_LO and S_LOAD, and two bytes pass
// S_RD_LO and S_LOAD, paced by the single registered read port of the frame store.
// Reset (rst, synchronous) clears position, checksum, tick count, timeout to 1000.
// Input stalls while a run is being emitted or the result register is held.
module pm_sensor_frame_parser_core (
  input logic         clk,
  input logic         rst,
  pmsfp_in_if.sink    item,
  pmsfp_out_if.source result,
  pmsfp_cfg_if.sink   cfg
);

  pmsfp_pkg::ctl_cmd_t cmd;
  pmsfp_pkg::dp_stat_t stat;

  assign cfg.ready = 1'b1;

  pmsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pmsfp_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .kind            (item.kind),
    .rx_byte         (item.rx_byte),
    .cfg_we          (cfg.valid && cfg.ready),
    .cfg_data        (cfg.data),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_status      (result.status),
    .out_field_index (result.field_index),
    .out_value       (result.value),
    .out_last        (result.last)
  );

  // Never take a word while a result would be overwritten
  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> (!result.valid || result.ready))
    else $error("input taken while result register held");

  // Status results are single and empty
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != pmsfp_pkg::STAT_FIELD) |->
      (result.last && result.value == 16'd0 && result.field_index == 4'd0))
    else $error("malformed status result");

  // Only the error byte closes a field run
  a_field_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == pmsfp_pkg::STAT_FIELD) |->
      (result.last == (result.field_index == pmsfp_pkg::FIELD_LAST)))
    else $error("last flag out of place in field run");

  // No input accepted while the field run is under way
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == pmsfp_pkg::STAT_FIELD && !result.last) |->
      !item.ready)
    else $error("input accepted during field run");

endmodule
